>>> rtl/rpc_pkg.sv
// rpc_pkg: shared types and constants for the rectilinear polygon containment block
// holds default sizes, fixed result field widths and the item mode codes
// no dependencies
package rpc_pkg;

  // default sizes of the vertex store and coordinates
  localparam int MAX_VERTICES_DEF = 1024;
  localparam int COORD_BITS_DEF   = 17;

  // fixed widths of the result fields
  localparam int AREA_W  = 35;
  localparam int COUNT_W = 11;
  localparam int OUT_W   = 1 + AREA_W + 1 + COUNT_W;

  // item modes
  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_POINT  = 2'd2,
    MODE_RECT   = 2'd3
  } mode_t;

endpackage

>>> rtl/rpc_ram.sv
// rpc_ram: generic single-clock ram, one write port and one registered read port
// used for the vertex store of the polygon containment block
// no dependencies
module rpc_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/rectilinear_polygon_containment.sv
// rectilinear_polygon_containment: vertex store with ray-casting point and rectangle queries
// depends on rpc_pkg and rpc_ram
//
// Usage: one item enters on the in_ stream (mode in in_tuser, coordinates in in_tdata)
// and exactly one result item leaves on the out_ stream. Clear and append items update
// the vertex count and go straight to the finish state. A point query reads every stored
// vertex once from the vertex ram, one vertex per cycle. A rectangle query tests the start
// of each side and every vertex coordinate that falls on that side, each test being one
// full scan of the ram. One item is worked on at a time; in_tready is high while the
// block is waiting for an item. The result sits in an output register, so the next item
// is accepted while a result still waits for out_tready; a finished result waits in the
// sequencer until the output register is free. Reset clears the vertex count and the
// output valid; the ram contents are not cleared and need no clearing pass, since only
// entries below the count are ever used.
module rectilinear_polygon_containment
  import rpc_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int COORD_BITS   = COORD_BITS_DEF,
  localparam int IN_W = ((4 * COORD_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // first_x, first_y, second_x, second_y, zero fill
  input  logic [IN_W-1:0]  in_tdata,
  // mode
  input  logic [1:0]       in_tuser,
  output logic             out_tvalid,
  input  logic             out_tready,
  // inside_res, area, status, count_now
  output logic [OUT_W-1:0] out_tdata
);

  localparam int CB    = COORD_BITS;
  localparam int AW    = $clog2(MAX_VERTICES);
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SIDE, ST_START, ST_SCAN, ST_CAND_SEL, ST_CAND_CHK, ST_FINISH
  } state_t;

  state_t           state_r;
  mode_t            mode_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CB-1:0]    x1_r, y1_r, x2_r, y2_r;
  logic [CB-1:0]    xlo_r, xhi_r, ylo_r, yhi_r;
  logic [CB:0]      span_x_r, span_y_r;
  logic [CB-1:0]    px_r, py_r;
  logic [CB-1:0]    prev_x_r, prev_y_r, first_x_r, first_y_r;
  logic [CNT_W-1:0] sa_r, rc_r, k_r;
  logic             rv_r, parity_r, inside_r, status_r;
  logic [1:0]       side_r;
  logic             out_tvalid_r;
  logic             out_inside_r, out_status_r;
  logic [AREA_W-1:0] out_area_r;
  logic [COUNT_W-1:0] out_count_r;

  // input unpacking
  logic [CB-1:0] in_x1, in_y1, in_x2, in_y2;
  mode_t         in_mode;
  assign in_x1   = in_tdata[CB-1:0];
  assign in_y1   = in_tdata[2*CB-1:CB];
  assign in_x2   = in_tdata[3*CB-1:2*CB];
  assign in_y2   = in_tdata[4*CB-1:3*CB];
  assign in_mode = mode_t'(in_tuser);

  logic accept;
  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  // vertex ram, entries hold {y, x}
  logic            ram_we;
  logic [AW-1:0]   ram_raddr;
  logic [2*CB-1:0] ram_rdata;
  logic            room;
  assign room      = (cnt_r < CNT_W'(MAX_VERTICES));
  assign ram_we    = accept && (in_mode == MODE_APPEND) && room;
  assign ram_raddr = (state_r == ST_CAND_SEL) ? k_r[AW-1:0] : sa_r[AW-1:0];

  rpc_ram #(.WIDTH(2 * CB), .DEPTH(MAX_VERTICES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata ({in_y1, in_x1}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic [CB-1:0] rd_x, rd_y;
  assign rd_x = ram_rdata[CB-1:0];
  assign rd_y = ram_rdata[2*CB-1:CB];

  // vertical edge strictly right of the point covering its y over [lo, hi)
  function automatic logic edge_hit(input logic [CB-1:0] ax, input logic [CB-1:0] ay,
                                    input logic [CB-1:0] bx, input logic [CB-1:0] by,
                                    input logic [CB-1:0] qx, input logic [CB-1:0] qy);
    logic [CB-1:0] lo;
    logic [CB-1:0] hi;
    lo = (ay < by) ? ay : by;
    hi = (ay < by) ? by : ay;
    return (ax == bx) && (qx < ax) && (qy >= lo) && (qy < hi);
  endfunction

  // edge tests of the scan
  logic scan_issue, scan_done, hit_cur, hit_close, scan_res;
  assign scan_issue = (sa_r < cnt_r);
  assign scan_done  = (rc_r == cnt_r);
  assign hit_cur    = rv_r && (rc_r != '0) &&
                      edge_hit(prev_x_r, prev_y_r, rd_x, rd_y, px_r, py_r);
  assign hit_close  = (cnt_r != '0) &&
                      edge_hit(prev_x_r, prev_y_r, first_x_r, first_y_r, px_r, py_r);
  assign scan_res   = parity_r ^ hit_close;

  // side of the rectangle under test
  logic          side_col;
  logic [CB-1:0] side_fix, side_lo, side_hi, cand_v;
  logic          cand_in;
  always_comb begin
    side_col = side_r[1];
    unique case (side_r)
      2'd0:    side_fix = y1_r;
      2'd1:    side_fix = y2_r;
      2'd2:    side_fix = x1_r;
      default: side_fix = x2_r;
    endcase
    side_lo = side_col ? ylo_r : xlo_r;
    side_hi = side_col ? yhi_r : xhi_r;
    cand_v  = side_col ? rd_y : rd_x;
    cand_in = (cand_v > side_lo) && (cand_v <= side_hi);
  end

  // area product
  logic [2*CB+1:0] area_prod;
  assign area_prod = span_x_r * span_y_r;

  // sequencer, state and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
      rv_r         <= 1'b0;
    end else begin
      // output register drains; the finish state refills it itself
      if (out_tvalid_r && out_tready && state_r != ST_FINISH) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            mode_r   <= in_mode;
            x1_r     <= in_x1;
            y1_r     <= in_y1;
            x2_r     <= in_x2;
            y2_r     <= in_y2;
            xlo_r    <= (in_x1 < in_x2) ? in_x1 : in_x2;
            xhi_r    <= (in_x1 < in_x2) ? in_x2 : in_x1;
            ylo_r    <= (in_y1 < in_y2) ? in_y1 : in_y2;
            yhi_r    <= (in_y1 < in_y2) ? in_y2 : in_y1;
            span_x_r <= ((in_x1 > in_x2) ? {1'b0, in_x1 - in_x2} : {1'b0, in_x2 - in_x1})
                        + (CB+1)'(1);
            span_y_r <= ((in_y1 > in_y2) ? {1'b0, in_y1 - in_y2} : {1'b0, in_y2 - in_y1})
                        + (CB+1)'(1);
            status_r <= 1'b0;
            inside_r <= 1'b0;
            unique case (in_mode)
              MODE_CLEAR: begin
                cnt_r   <= '0;
                state_r <= ST_FINISH;
              end
              MODE_APPEND: begin
                if (room) begin
                  cnt_r <= cnt_r + CNT_W'(1);
                end else begin
                  status_r <= 1'b1;
                end
                state_r <= ST_FINISH;
              end
              MODE_POINT: begin
                px_r    <= in_x1;
                py_r    <= in_y1;
                state_r <= ST_START;
              end
              MODE_RECT: begin
                side_r  <= 2'd0;
                state_r <= ST_SIDE;
              end
            endcase
          end
        end
        // start of a side is the first point tested
        ST_SIDE: begin
          px_r    <= side_col ? side_fix : side_lo;
          py_r    <= side_col ? side_lo : side_fix;
          k_r     <= '0;
          state_r <= ST_START;
        end
        ST_START: begin
          sa_r     <= '0;
          rc_r     <= '0;
          rv_r     <= 1'b0;
          parity_r <= 1'b0;
          state_r  <= ST_SCAN;
        end
        // stream the vertices, one edge test per cycle, closing edge at the end
        ST_SCAN: begin
          if (scan_issue) begin
            sa_r <= sa_r + CNT_W'(1);
          end
          rv_r <= scan_issue;
          if (rv_r) begin
            if (rc_r == '0) begin
              first_x_r <= rd_x;
              first_y_r <= rd_y;
            end
            prev_x_r <= rd_x;
            prev_y_r <= rd_y;
            rc_r     <= rc_r + CNT_W'(1);
            parity_r <= parity_r ^ hit_cur;
          end
          if (scan_done) begin
            if (mode_r == MODE_POINT) begin
              inside_r <= scan_res;
              state_r  <= ST_FINISH;
            end else if (!scan_res) begin
              inside_r <= 1'b0;
              state_r  <= ST_FINISH;
            end else begin
              state_r <= ST_CAND_SEL;
            end
          end
        end
        // next vertex coordinate that may change parity along the side
        ST_CAND_SEL: begin
          if (k_r < cnt_r) begin
            state_r <= ST_CAND_CHK;
          end else if (side_r == 2'd3) begin
            inside_r <= 1'b1;
            state_r  <= ST_FINISH;
          end else begin
            side_r  <= side_r + 2'd1;
            state_r <= ST_SIDE;
          end
        end
        ST_CAND_CHK: begin
          k_r <= k_r + CNT_W'(1);
          if (cand_in) begin
            px_r    <= side_col ? side_fix : cand_v;
            py_r    <= side_col ? cand_v : side_fix;
            state_r <= ST_START;
          end else begin
            state_r <= ST_CAND_SEL;
          end
        end
        // hand the result to the output register once it is free
        ST_FINISH: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_inside_r <= inside_r;
            out_status_r <= status_r;
            out_count_r  <= COUNT_W'(cnt_r);
            unique case (mode_r)
              MODE_RECT:  out_area_r <= AREA_W'(area_prod);
              MODE_POINT: out_area_r <= AREA_W'(1);
              default:    out_area_r <= '0;
            endcase
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_count_r, out_status_r, out_area_r, out_inside_r};

endmodule

>>> rtl/rpc_check.sv
// rpc_check: port-level assertions for the polygon containment block
// depends on rpc_pkg; bound to the top level at the end of this file
module rpc_check
  import rpc_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input logic             clk,
  input logic             rst_n,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  logic               f_inside, f_status;
  logic [AREA_W-1:0]  f_area;
  logic [COUNT_W-1:0] f_count;
  assign f_inside = out_tdata[0];
  assign f_area   = out_tdata[AREA_W:1];
  assign f_status = out_tdata[AREA_W+1];
  assign f_count  = out_tdata[OUT_W-1:AREA_W+2];

  // stalled result item holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item changed while stalled");

  // a dropped vertex only happens with a full store
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && f_status |-> f_count == COUNT_W'(MAX_VERTICES))
    else $error("store full flagged below capacity");

  // a dropped append carries no query answer
  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && f_status |-> !f_inside && f_area == '0)
    else $error("status item carries query fields");

  // inside only comes from a query, which always has an area
  a_inside_area: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && f_inside |-> f_area != '0)
    else $error("inside reported without area");

endmodule

bind rectilinear_polygon_containment rpc_check #(.MAX_VERTICES(MAX_VERTICES)) u_rpc_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
